// File: design/psip_pkg.sv
package psip_pkg;

    localparam int COORD_W = 20;
    localparam int IDX_W   = 4;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic [IDX_W-1:0]          t_idx;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TEST = 1'b1
    } t_req;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_vertex;

    // point moving down the edge chain
    typedef struct packed {
        logic   valid;
        logic   last;
        logic   parity;
        t_coord x;
        t_coord y;
    } t_point;

endpackage

// File: design/psip_req_if.sv
interface psip_req_if;
    import psip_pkg::*;

    logic   valid;
    logic   ready;
    t_req   req_type;
    t_idx   vertex_index;
    t_coord coord_x;
    t_coord coord_y;
    logic   last;

    modport source (output valid, req_type, vertex_index, coord_x, coord_y, last,
                    input ready);
    modport sink   (input valid, req_type, vertex_index, coord_x, coord_y, last,
                    output ready);
endinterface

// File: design/psip_rsp_if.sv
interface psip_rsp_if;
    logic valid;
    logic ready;
    logic point_inside;
    logic any_inside;
    logic all_inside;
    logic group_end;

    modport source (output valid, point_inside, any_inside, all_inside, group_end,
                    input ready);
    modport sink   (input valid, point_inside, any_inside, all_inside, group_end,
                    output ready);
endinterface

// File: design/psip_cell.sv
module psip_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_we,
    input  psip_pkg::t_vertex  i_wr_vtx,
    input  logic               i_active,
    input  psip_pkg::t_vertex  i_next,
    output psip_pkg::t_vertex  o_vtx,
    input  psip_pkg::t_point   i_pt,
    output psip_pkg::t_point   o_pt,
    output logic               o_busy
);
    import psip_pkg::*;

    t_vertex r_vtx;
    t_point  r_pa;
    t_point  r_pb;
    t_prod   r_lhs;
    t_prod   r_rhs;
    logic    r_cross;
    logic    r_up;

    t_diff   dy_pt;
    t_diff   dx_edge;
    t_diff   dx_pt;
    t_diff   dy_edge;
    t_prod   n_lhs;
    t_prod   n_rhs;
    logic    above_a;
    logic    above_b;
    logic    n_cross;
    logic    hit;
    t_point  n_pb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_vtx <= i_wr_vtx;
        end
    end

    assign o_vtx = r_vtx;

    // stage a: side test and the two cross products
    assign above_a = r_vtx.y > i_pt.y;
    assign above_b = i_next.y > i_pt.y;
    assign n_cross = i_active && (above_a != above_b);
    assign dy_pt   = DIFF_W'(i_pt.y) - DIFF_W'(r_vtx.y);
    assign dx_edge = DIFF_W'(i_next.x) - DIFF_W'(r_vtx.x);
    assign dx_pt   = DIFF_W'(i_pt.x) - DIFF_W'(r_vtx.x);
    assign dy_edge = DIFF_W'(i_next.y) - DIFF_W'(r_vtx.y);
    assign n_lhs   = dy_pt * dx_edge;
    assign n_rhs   = dx_pt * dy_edge;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lhs   <= n_lhs;
            r_rhs   <= n_rhs;
            r_cross <= n_cross;
            r_up    <= above_b;
        end
    end

    // stage b: compare and flip parity
    assign hit = r_up ? (r_lhs >= r_rhs) : (r_lhs <= r_rhs);

    always_comb begin
        n_pb        = r_pa;
        n_pb.parity = r_pa.parity ^ (r_cross & hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa.valid <= 1'b0;
            r_pb.valid <= 1'b0;
        end else if (i_adv) begin
            r_pa <= i_pt;
            r_pb <= n_pb;
        end
    end

    assign o_pt   = r_pb;
    assign o_busy = r_pa.valid | r_pb.valid;

endmodule

// File: design/point_set_in_polygon_test_unit.sv
// point-in-polygon tester, crossing number over a chain of edge cells
//
// i_req carries one request per transfer: a vertex load (req_type 0) writes
// one polygon slot, with last setting the vertex count to slot + 1; a test
// (req_type 1) sends one point down the chain. o_rsp gives one result per
// test: the point's parity plus any/all over the group closed by last.
//
// every cell owns one vertex and its outgoing edge and passes each point
// through its stage a and stage b registers before the output register.
// tests are accepted one per cycle while o_rsp is not stalled. a load waits
// until no point is left in the chain and o_rsp is not stalled.
//
// reset empties the chain and the output register, clears the vertex count
// (all points outside) and restarts the group. vertex slots hold garbage
// until loaded. when o_rsp is stalled the whole chain holds and i_req.ready
// drops; nothing is lost.
module point_set_in_polygon_test_unit #(
    parameter int MAX_VERTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psip_req_if.sink   i_req,
    psip_rsp_if.source o_rsp
);
    import psip_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTS + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_any;
    logic             r_all;
    logic             r_out_valid;
    logic             r_out_inside;
    logic             r_out_any;
    logic             r_out_all;
    logic             r_out_end;

    logic             adv;
    logic             busy;
    logic             in_xfer;
    logic             load_xfer;
    logic             load_ok;
    logic             n_any;
    logic             n_all;
    t_point           pt_in;
    t_point           pt_out;
    t_vertex          wr_vtx;

    t_point           pts   [MAX_VERTS+1];
    t_vertex          vtxs  [MAX_VERTS];
    logic [MAX_VERTS-1:0] cell_busy;

    assign adv       = !r_out_valid || o_rsp.ready;
    assign busy      = |cell_busy;
    assign i_req.ready = adv && ((i_req.req_type == REQ_TEST) || !busy);
    assign in_xfer   = i_req.valid && i_req.ready;
    assign load_ok   = int'(i_req.vertex_index) < MAX_VERTS;
    assign load_xfer = in_xfer && (i_req.req_type == REQ_LOAD) && load_ok;
    assign n_count   = CNT_W'(int'(i_req.vertex_index) + 1);
    assign wr_vtx.x  = i_req.coord_x;
    assign wr_vtx.y  = i_req.coord_y;

    always_comb begin
        pt_in.valid  = in_xfer && (i_req.req_type == REQ_TEST);
        pt_in.last   = i_req.last;
        pt_in.parity = 1'b0;
        pt_in.x      = i_req.coord_x;
        pt_in.y      = i_req.coord_y;
    end

    assign pts[0] = pt_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (load_xfer && i_req.last) begin
            r_count <= n_count;
        end
    end

    for (genvar k = 0; k < MAX_VERTS; k++) begin : g_cell
        t_vertex next_vtx;
        logic    active;
        logic    we;

        if (k + 1 < MAX_VERTS) begin : g_mid
            assign next_vtx = (r_count == CNT_W'(k + 1)) ? vtxs[0] : vtxs[k+1];
        end else begin : g_end
            assign next_vtx = vtxs[0];
        end

        assign active = r_count > CNT_W'(k);
        assign we     = load_xfer && (int'(i_req.vertex_index) == k);

        psip_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_we     (we),
            .i_wr_vtx (wr_vtx),
            .i_active (active),
            .i_next   (next_vtx),
            .o_vtx    (vtxs[k]),
            .i_pt     (pts[k]),
            .o_pt     (pts[k+1]),
            .o_busy   (cell_busy[k])
        );
    end

    assign pt_out = pts[MAX_VERTS];
    assign n_any  = r_any | pt_out.parity;
    assign n_all  = r_all & pt_out.parity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_any       <= 1'b0;
            r_all       <= 1'b1;
        end else if (adv) begin
            r_out_valid <= pt_out.valid;
            if (pt_out.valid) begin
                r_any <= pt_out.last ? 1'b0 : n_any;
                r_all <= pt_out.last ? 1'b1 : n_all;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && pt_out.valid) begin
            r_out_inside <= pt_out.parity;
            r_out_any    <= n_any;
            r_out_all    <= n_all;
            r_out_end    <= pt_out.last;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.point_inside = r_out_inside;
    assign o_rsp.any_inside   = r_out_any;
    assign o_rsp.all_inside   = r_out_all;
    assign o_rsp.group_end    = r_out_end;

endmodule

// File: sim/point_set_in_polygon_test_unit_tb.sv
module point_set_in_polygon_test_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psip_pkg::*;

    localparam int MAX_VERTS    = 16;
    localparam int COORD_MIN    = -524288;
    localparam int COORD_MAX    = 524287;
    localparam int RANDOM_ITEMS = 400;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 2 * MAX_VERTS + 8;

    typedef struct {
        t_req   kind;
        t_idx   slot;
        t_coord x;
        t_coord y;
        logic   last;
        logic   drain;
    } t_req_item;

    typedef struct packed {
        logic point_inside;
        logic any_inside;
        logic all_inside;
        logic group_end;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    psip_req_if req_bus();
    psip_rsp_if rsp_bus();

    point_set_in_polygon_test_unit #(
        .MAX_VERTS(MAX_VERTS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    // requests waiting to be sent and verdicts waiting to come back
    t_req_item request_backlog[$];
    t_verdict  pending_verdicts[$];

    // predicted polygon and group state
    t_coord poly_x[MAX_VERTS];
    t_coord poly_y[MAX_VERTS];
    int     poly_count;
    logic   grp_any;
    logic   grp_all;

    // stimulus-side view of the polygon, used to shape points and pick load last flags
    int gen_written;
    int gen_count;
    int gen_px[MAX_VERTS];
    int gen_py[MAX_VERTS];
    bit want_drain;

    t_req_item cur_req;
    bit        req_busy;
    bit        req_fired;
    int        gap_left;
    int        burst_left;

    logic [15:0] stall_pat;
    int          stall_phase;

    t_verdict got_rsp;
    t_verdict want_rsp;
    string    field_name[4] = '{"group_end", "all_inside", "any_inside", "point_inside"};
    int       mismatches;
    int       cycle_count;

    function automatic logic odd_crossings(input t_coord px, input t_coord py);
        longint lpx, lpy, x1, y1, x2, y2, dy, lhs, rhs;
        int     j;
        logic   parity;
        lpx = px;
        lpy = py;
        parity = 1'b0;
        for (int i = 0; i < poly_count; i++) begin
            j = (i + 1 == poly_count) ? 0 : i + 1;
            x1 = poly_x[i];
            y1 = poly_y[i];
            x2 = poly_x[j];
            y2 = poly_y[j];
            // skip edges with both ends on the same side of the ray
            if ((y1 > lpy) != (y2 > lpy)) begin
                dy  = y2 - y1;
                lhs = (lpy - y1) * (x2 - x1);
                rhs = (lpx - x1) * dy;
                if ((dy > 0) ? (lhs >= rhs) : (lhs <= rhs)) begin
                    parity = ~parity;
                end
            end
        end
        return parity;
    endfunction

    task automatic track_request(input t_req_item r);
        t_verdict v;
        if (r.kind == REQ_LOAD) begin
            poly_x[r.slot] = r.x;
            poly_y[r.slot] = r.y;
            if (r.last) begin
                poly_count = int'(r.slot) + 1;
            end
        end else begin
            v.point_inside = odd_crossings(r.x, r.y);
            grp_any = grp_any | v.point_inside;
            grp_all = grp_all & v.point_inside;
            v.any_inside = grp_any;
            v.all_inside = grp_all;
            v.group_end  = r.last;
            pending_verdicts.push_back(v);
            if (r.last) begin
                grp_any = 1'b0;
                grp_all = 1'b1;
            end
        end
    endtask

    function automatic int clamp_coord(input int v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 1048575)) - 524288;
    endfunction

    function automatic int near(input int c, input int span);
        return clamp_coord(c + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic add_load(input int slot, input int x, input int y, input logic last);
        t_req_item r;
        r.kind  = REQ_LOAD;
        r.slot  = t_idx'(slot);
        r.x     = t_coord'(x);
        r.y     = t_coord'(y);
        r.last  = last;
        r.drain = 1'b0;
        request_backlog.push_back(r);
        gen_written = gen_written | (1 << slot);
        gen_px[slot] = x;
        gen_py[slot] = y;
        if (last) begin
            gen_count = slot + 1;
        end
    endtask

    task automatic add_test(input int x, input int y, input logic last);
        t_req_item r;
        r.kind  = REQ_TEST;
        r.slot  = t_idx'($urandom_range(0, 15));
        r.x     = t_coord'(x);
        r.y     = t_coord'(y);
        r.last  = last;
        r.drain = want_drain;
        want_drain = 1'b0;
        request_backlog.push_back(r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // request driver: transfers change at the falling edge
    always @(posedge i_clk) begin
        req_fired = i_rst_n && req_bus.valid && req_bus.ready;
        if (req_fired) begin
            track_request(cur_req);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_busy || req_fired) begin
                req_busy = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_backlog.size() > 0 &&
                             !(request_backlog[0].drain && pending_verdicts.size() > 0)) begin
                    cur_req  = request_backlog.pop_front();
                    req_busy = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            req_bus.valid        <= req_busy;
            req_bus.req_type     <= cur_req.kind;
            req_bus.vertex_index <= cur_req.slot;
            req_bus.coord_x      <= cur_req.x;
            req_bus.coord_y      <= cur_req.y;
            req_bus.last         <= cur_req.last;
        end
    end

    // result sink stalls on a rotating pattern, reselected now and then
    always @(negedge i_clk) begin
        if (stall_phase <= 0) begin
            stall_phase = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0: begin
                    stall_pat = 16'hFFFF;
                end
                1: begin
                    stall_pat = 16'($urandom);
                end
                default: begin
                    stall_pat = 16'($urandom) | 16'h0101;
                end
            endcase
            if (stall_pat == 16'h0000) begin
                stall_pat = 16'hFFFF;
            end
        end
        stall_phase--;
        stall_pat = {stall_pat[14:0], stall_pat[15]};
        rsp_bus.ready <= stall_pat[15];
    end

    // result monitor
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got_rsp = {rsp_bus.point_inside, rsp_bus.any_inside,
                       rsp_bus.all_inside, rsp_bus.group_end};
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result transfer, expected none, actual %b",
                         $time, got_rsp);
            end else begin
                want_rsp = pending_verdicts.pop_front();
                for (int b = 0; b < 4; b++) begin
                    if (got_rsp[b] !== want_rsp[b]) begin
                        mismatches++;
                        $display("%0t: %s mismatch, expected %b, actual %b",
                                 $time, field_name[b], want_rsp[b], got_rsp[b]);
                    end
                end
            end
        end
    end

    initial begin
        int n, k, g, p, groups, pts, scale, cx, cy, pick, mask;
        int lo_x, hi_x, lo_y, hi_y, px, py, start_size;

        i_rst_n              = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_LOAD;
        req_bus.vertex_index = '0;
        req_bus.coord_x      = '0;
        req_bus.coord_y      = '0;
        req_bus.last         = 1'b0;
        rsp_bus.ready        = 1'b0;
        cur_req              = '{REQ_LOAD, '0, '0, '0, 1'b0, 1'b0};
        req_busy             = 1'b0;
        req_fired            = 1'b0;
        gap_left             = 0;
        burst_left           = 8;
        stall_pat            = 16'hFFFF;
        stall_phase          = 0;
        poly_count           = 0;
        grp_any              = 1'b0;
        grp_all              = 1'b1;
        gen_written          = 0;
        gen_count            = 0;
        want_drain           = 1'b0;
        mismatches           = 0;
        cycle_count          = 0;

        // no polygon yet: everything outside
        add_test(0, 0, 1'b0);
        add_test(COORD_MAX, COORD_MIN, 1'b1);
        // single vertex, degenerate edge
        add_load(0, 80, 80, 1'b1);
        add_test(0, 80, 1'b0);
        add_test(-16, 0, 1'b1);
        // full-range square
        add_load(0, COORD_MIN, COORD_MIN, 1'b0);
        add_load(1, COORD_MAX, COORD_MIN, 1'b0);
        add_load(2, COORD_MAX, COORD_MAX, 1'b0);
        add_load(3, COORD_MIN, COORD_MAX, 1'b1);
        want_drain = 1'b1;
        add_test(0, 0, 1'b0);
        add_test(COORD_MIN, COORD_MIN, 1'b0);
        add_test(COORD_MAX, 0, 1'b0);
        add_test(COORD_MIN, 0, 1'b0);
        add_test(0, COORD_MAX, 1'b1);
        // triangle with a horizontal edge
        add_load(0, 0, 0, 1'b0);
        add_load(1, 160, 0, 1'b0);
        add_load(2, 80, 160, 1'b1);
        add_test(80, 0, 1'b0);
        add_test(80, 160, 1'b0);
        add_test(80, 80, 1'b1);
        add_test(200, 80, 1'b1);

        start_size = request_backlog.size();
        while (request_backlog.size() - start_size < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    case ($urandom_range(0, 9))
                        0: n = MAX_VERTS;
                        1: n = $urandom_range(1, 2);
                        default: n = $urandom_range(3, 8);
                    endcase
                    case ($urandom_range(0, 4))
                        0: scale = 16;
                        1: scale = 256;
                        2: scale = 4096;
                        3: scale = 65536;
                        default: scale = 524288;
                    endcase
                    cx = rand_coord();
                    cy = rand_coord();
                    if ($urandom_range(0, 3) == 0) begin
                        for (k = n - 2; k >= 0; k--) begin
                            add_load(k, near(cx, scale), near(cy, scale), 1'b0);
                        end
                    end else begin
                        for (k = 0; k < n - 1; k++) begin
                            add_load(k, near(cx, scale), near(cy, scale), 1'b0);
                        end
                    end
                    add_load(n - 1, near(cx, scale), near(cy, scale), 1'b1);
                    lo_x = gen_px[0];
                    hi_x = gen_px[0];
                    lo_y = gen_py[0];
                    hi_y = gen_py[0];
                    for (k = 1; k < n; k++) begin
                        if (gen_px[k] < lo_x) lo_x = gen_px[k];
                        if (gen_px[k] > hi_x) hi_x = gen_px[k];
                        if (gen_py[k] < lo_y) lo_y = gen_py[k];
                        if (gen_py[k] > hi_y) hi_y = gen_py[k];
                    end
                    lo_x = clamp_coord(lo_x - 1);
                    hi_x = clamp_coord(hi_x + 1);
                    lo_y = clamp_coord(lo_y - 1);
                    hi_y = clamp_coord(hi_y + 1);
                    groups = $urandom_range(1, 3);
                    for (g = 0; g < groups; g++) begin
                        pts = $urandom_range(1, 6);
                        for (p = 0; p < pts; p++) begin
                            pick = $urandom_range(0, n - 1);
                            px = lo_x + int'($urandom_range(0, hi_x - lo_x));
                            py = lo_y + int'($urandom_range(0, hi_y - lo_y));
                            case ($urandom_range(0, 3))
                                0: begin
                                    px = gen_px[pick];
                                    py = gen_py[pick];
                                end
                                1: begin
                                    py = gen_py[pick];
                                end
                                default: begin
                                end
                            endcase
                            add_test(px, py, p == pts - 1);
                        end
                    end
                end
                6: begin
                    repeat ($urandom_range(1, 4)) begin
                        add_test(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
                    end
                end
                7: begin
                    add_load($urandom_range(0, 15), rand_coord(), rand_coord(), 1'b0);
                end
                8: begin
                    // count change only where this slot and every slot below are already loaded
                    pick = $urandom_range(0, 15);
                    mask = (1 << (pick + 1)) - 1;
                    add_load(pick, rand_coord(), rand_coord(), (gen_written & mask) == mask);
                end
                default: begin
                    want_drain = 1'b1;
                end
            endcase
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((request_backlog.size() > 0 || req_busy || pending_verdicts.size() > 0) &&
               cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
        end
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("point_set_in_polygon_test_unit verification failed");
        end else begin
            repeat (SETTLE) @(posedge i_clk);
            if (mismatches == 0) begin
                $display("point_set_in_polygon_test_unit verification clean");
            end else begin
                $display("point_set_in_polygon_test_unit verification failed");
            end
        end
        $finish;
    end

endmodule

// File: sim.f
design/psip_pkg.sv
design/psip_req_if.sv
design/psip_rsp_if.sv
design/psip_cell.sv
design/point_set_in_polygon_test_unit.sv
sim/point_set_in_polygon_test_unit_tb.sv
